// ----- rtl/spsc_pkg.sv -----
// Shared types and constants for the stack pop sequence checker.
// No dependencies; spsc_ifs and the top level refer to this package.
`default_nettype none

package spsc_pkg;

	// Largest sequence length and stack capacity the block supports
	localparam int MAX_LENGTH = 1024;

	// Width of the pop value, config data and config registers
	localparam int VAL_W = 11;

	// Counters (depth, next value, items) must reach MAX_LENGTH + 1
	localparam int CNT_W = $clog2(MAX_LENGTH + 2);

	// Stack memory address width
	localparam int ADDR_W = $clog2(MAX_LENGTH);

	// Common width for comparing counters against values
	localparam int CMP_W = (CNT_W > VAL_W) ? CNT_W : VAL_W;

	typedef logic [VAL_W-1:0]  val_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CMP_W-1:0]  cmp_t;

	localparam cmp_t MAX_CMP = CMP_W'(MAX_LENGTH);

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_CAPACITY = 1'b0,
		REG_LENGTH   = 1'b1
	} reg_idx_t;

	// Sequencer states
	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_CHECK  = 5'b00010,
		S_PUSH   = 5'b00100,
		S_POPRD  = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/spsc_ifs.sv -----
// Valid/ready channel interfaces for the stack pop sequence checker.
// Depends on spsc_pkg for payload types.
`default_nettype none

// Pop value channel
interface spsc_pop_if;
	logic          valid;
	logic          ready;
	spsc_pkg::val_t pop_value;

	modport source (output valid, output pop_value, input ready);
	modport sink   (input valid, input pop_value, output ready);
endinterface

// Verdict channel
interface spsc_verdict_if;
	logic valid;
	logic ready;
	logic is_valid;

	modport source (output valid, output is_valid, input ready);
	modport sink   (input valid, input is_valid, output ready);
endinterface

// Configuration write channel
interface spsc_cfg_if;
	logic               valid;
	logic               ready;
	spsc_pkg::reg_idx_t index;
	spsc_pkg::val_t     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/spsc_ram.sv -----
// Generic single-clock RAM, one write port and one read port, registered read.
// No package dependencies.
`default_nettype none

module spsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/stack_pop_sequence_checker.sv -----
// Stack pop sequence checker: top level with sequencer and stack memory.
// Depends on spsc_pkg, the channel interfaces in spsc_ifs and spsc_ram.
//
// The block takes one pop value per beat and decides whether the whole
// sequence of sequence_length values is a possible pop order of a stack that
// is fed 1..sequence_length in rising order and holds at most capacity
// entries. The stack lives in a MAX_LENGTH-entry RAM with registered read;
// the top entry is also kept in a register. An item goes from CHECK straight
// to FINISH when the top matches and no refill read is needed, through POPRD
// when the pop must fetch the new top from the RAM, and through PUSH, one RAM
// write per cycle, before the match or the failure. Once a sequence has failed
// its remaining items go from CHECK straight to FINISH. On the last item of
// a sequence one verdict beat is produced and the state is cleared; the block
// keeps taking items while a verdict waits, and stalls only if a second
// verdict is ready before the first was taken. Config writes are always ready
// and take effect at once. Values of 0 or above sequence_length never match.
`default_nettype none

module stack_pop_sequence_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	spsc_pop_if.sink        pop_ch,
	spsc_verdict_if.source  verdict_ch,
	spsc_cfg_if.sink        cfg
);

	spsc_pkg::state_t state_q;
	spsc_pkg::state_t state_d;

	spsc_pkg::val_t capacity_q;
	spsc_pkg::val_t length_q;

	spsc_pkg::cnt_t depth_q;
	spsc_pkg::cnt_t next_q;
	spsc_pkg::cnt_t items_q;
	spsc_pkg::cnt_t top_q;
	logic           failed_q;
	spsc_pkg::val_t value_q;

	logic out_valid_q;
	logic is_valid_q;

	// Effective limits
	spsc_pkg::cmp_t cap_ext;
	spsc_pkg::cmp_t len_ext;
	spsc_pkg::cmp_t cap_eff;
	spsc_pkg::cmp_t len_eff;
	spsc_pkg::cmp_t depth_ext;
	spsc_pkg::cmp_t next_ext;
	spsc_pkg::cmp_t top_ext;
	spsc_pkg::cmp_t val_ext;
	spsc_pkg::cmp_t items_inc;

	logic top_hit;
	logic last_item;
	logic emit;

	// RAM ports
	logic           wr_en;
	logic           rd_en;
	spsc_pkg::addr_t rd_addr;
	spsc_pkg::cnt_t rd_data;

	assign cap_ext = spsc_pkg::CMP_W'(capacity_q);
	assign len_ext = spsc_pkg::CMP_W'(length_q);
	assign cap_eff = (cap_ext > spsc_pkg::MAX_CMP) ? spsc_pkg::MAX_CMP : cap_ext;
	assign len_eff = (len_ext == '0) ? spsc_pkg::CMP_W'(1) :
	                 (len_ext > spsc_pkg::MAX_CMP) ? spsc_pkg::MAX_CMP : len_ext;

	assign depth_ext = spsc_pkg::CMP_W'(depth_q);
	assign next_ext  = spsc_pkg::CMP_W'(next_q);
	assign top_ext   = spsc_pkg::CMP_W'(top_q);
	assign val_ext   = spsc_pkg::CMP_W'(value_q);
	assign items_inc = spsc_pkg::CMP_W'(items_q) + spsc_pkg::CMP_W'(1);

	assign top_hit   = (depth_q != '0) && (top_ext == val_ext);
	assign last_item = (items_inc >= len_eff);
	assign emit      = (state_q == spsc_pkg::S_FINISH) && last_item &&
	                   (!out_valid_q || verdict_ch.ready);

	assign pop_ch.ready     = (state_q == spsc_pkg::S_IDLE);
	assign cfg.ready        = 1'b1;
	assign verdict_ch.valid = out_valid_q;
	assign verdict_ch.is_valid = is_valid_q;

	// Push writes at the current depth; a pop refills the top from below it
	assign wr_en   = (state_q == spsc_pkg::S_PUSH) && !failed_q &&
	                 (next_ext <= len_eff) && (depth_ext < cap_eff) &&
	                 (next_ext != val_ext);
	assign rd_en   = (state_q == spsc_pkg::S_CHECK) && !failed_q && top_hit &&
	                 (depth_q > spsc_pkg::CNT_W'(1));
	assign rd_addr = spsc_pkg::ADDR_W'(depth_q - spsc_pkg::CNT_W'(2));

	spsc_ram #(
		.WIDTH (spsc_pkg::CNT_W),
		.DEPTH (spsc_pkg::MAX_LENGTH)
	) u_stack_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (depth_q[spsc_pkg::ADDR_W-1:0]),
		.wr_data (next_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			spsc_pkg::S_IDLE: begin
				if (pop_ch.valid) state_d = spsc_pkg::S_CHECK;
			end
			spsc_pkg::S_CHECK: begin
				if (failed_q) state_d = spsc_pkg::S_FINISH;
				else if (top_hit) state_d = rd_en ? spsc_pkg::S_POPRD : spsc_pkg::S_FINISH;
				else state_d = spsc_pkg::S_PUSH;
			end
			spsc_pkg::S_PUSH: begin
				if (!wr_en) state_d = spsc_pkg::S_FINISH;
			end
			spsc_pkg::S_POPRD: begin
				state_d = spsc_pkg::S_FINISH;
			end
			spsc_pkg::S_FINISH: begin
				if (!last_item || emit) state_d = spsc_pkg::S_IDLE;
			end
			default: state_d = spsc_pkg::S_IDLE;
		endcase
	end

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= spsc_pkg::VAL_W'(1024);
			length_q   <= spsc_pkg::VAL_W'(1024);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				spsc_pkg::REG_CAPACITY: capacity_q <= cfg.data;
				spsc_pkg::REG_LENGTH:   length_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// Pop value capture
	always_ff @(posedge clk) begin
		if (pop_ch.valid && pop_ch.ready) begin
			value_q <= pop_ch.pop_value;
		end
	end

	// Stack bookkeeping and sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= spsc_pkg::S_IDLE;
			depth_q  <= '0;
			next_q   <= spsc_pkg::CNT_W'(1);
			items_q  <= '0;
			failed_q <= 1'b0;
			top_q    <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				spsc_pkg::S_CHECK: begin
					if (!failed_q && top_hit) depth_q <= depth_q - spsc_pkg::CNT_W'(1);
				end
				spsc_pkg::S_PUSH: begin
					if (!failed_q) begin
						if (next_ext > len_eff || depth_ext >= cap_eff) begin
							failed_q <= 1'b1;
						end else if (next_ext == val_ext) begin
							next_q <= next_q + spsc_pkg::CNT_W'(1);
						end else begin
							top_q   <= next_q;
							depth_q <= depth_q + spsc_pkg::CNT_W'(1);
							next_q  <= next_q + spsc_pkg::CNT_W'(1);
						end
					end
				end
				spsc_pkg::S_POPRD: begin
					top_q <= rd_data;
				end
				spsc_pkg::S_FINISH: begin
					if (!last_item) begin
						items_q <= spsc_pkg::CNT_W'(items_inc);
					end else if (emit) begin
						depth_q  <= '0;
						next_q   <= spsc_pkg::CNT_W'(1);
						items_q  <= '0;
						failed_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Verdict output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			is_valid_q  <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
			is_valid_q  <= !failed_q;
		end else if (verdict_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	// Stack never grows past the memory
	assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= spsc_pkg::CNT_W'(spsc_pkg::MAX_LENGTH))
		else $error("stack depth beyond memory size");

	// Every stacked entry is a value already pushed
	assert property (@(posedge clk) disable iff (!arst_n)
		depth_q < next_q)
		else $error("stack depth exceeds pushed value count");

	// An accepted pop value is examined in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop_ch.valid && pop_ch.ready) |=> (state_q == spsc_pkg::S_CHECK))
		else $error("accepted beat not examined");

	// A refill read is only issued with an entry left below the popped top
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> (depth_q != '0))
		else $error("refill read with empty stack");
`endif

endmodule

`default_nettype wire
